[hdl/pom_pkg.sv]
// shared types and constants of the polyphonic oscillator mixer
`timescale 1ns / 1ps
package pom_pkg;

  localparam int IDX_W      = 4;
  localparam int VOL_W      = 9;
  localparam int STEP_W     = 24;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int WAVE_W     = 17;
  localparam int WT_W       = 8;
  localparam int NUM_WTS    = 4;
  localparam int HCNT_W     = 3;
  localparam int SUM_W      = 28;
  localparam int DIV_W      = 26;
  localparam int DEN_W      = 10;
  localparam int PW_W       = 16;
  localparam int GAIN_W     = 9;

  localparam logic [15:0] PULSE_WIDTH_RST = 16'd32768;
  localparam logic [31:0] WEIGHTS_RST     = 32'd255;
  localparam logic [8:0]  GAIN_RST        = 9'd64;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WAVE_TYPE   = 3'd0,
    REG_PULSE_WIDTH = 3'd1,
    REG_TRI_STEPPED = 3'd2,
    REG_SAW_STEPPED = 3'd3,
    REG_HARM_WTS    = 3'd4,
    REG_MASTER_GAIN = 3'd5
  } cfg_reg_e;

  typedef enum logic [2:0] {
    WAVE_PULSE = 3'd0,
    WAVE_TRI   = 3'd1,
    WAVE_SAW   = 3'd2,
    WAVE_HARM  = 3'd3
  } wave_e;

  typedef logic signed [WAVE_W-1:0] wave_t;

endpackage

[hdl/pom_in_if.sv]
// input channel: tick and set-note transactions
`timescale 1ns / 1ps
interface pom_in_if;
  logic                         valid;
  logic                         ready;
  logic                         mode;
  logic [pom_pkg::IDX_W-1:0]    note_index;
  logic [pom_pkg::VOL_W-1:0]    note_volume;
  logic [pom_pkg::STEP_W-1:0]   phase_step;
  modport source (output valid, mode, note_index, note_volume, phase_step, input ready);
  modport sink (input valid, mode, note_index, note_volume, phase_step, output ready);
endinterface

[hdl/pom_out_if.sv]
// output channel: mixed samples
`timescale 1ns / 1ps
interface pom_out_if #(parameter int OutBits = 16);
  logic                      valid;
  logic                      ready;
  logic signed [OutBits-1:0] sample_out;
  logic                      clipped;
  modport source (output valid, sample_out, clipped, input ready);
  modport sink (input valid, sample_out, clipped, output ready);
endinterface

[hdl/pom_cfg_if.sv]
// configuration write channel
`timescale 1ns / 1ps
interface pom_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [pom_pkg::CFG_IDX_W-1:0]     index;
  logic [pom_pkg::CFG_DATA_W-1:0]    data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[hdl/polyphonic_oscillator_mixer.sv]
// top level: note memories, per-tick note walk, harmonic sum and mixer
// a set-note is written when accepted; a tick walks the notes one at a time
// simple waves: per note, read, evaluate, multiply and accumulate; harmonic
// sine adds a rom read and sum per harmonic and the 26-step divider (skipped
// when the weights sum to zero); then gain scale, and emit once output is free
// reset clears datapath registers and note valid bits, so all notes read as zero
`timescale 1ns / 1ps
module polyphonic_oscillator_mixer #(
  parameter int NOTES        = 16,
  parameter int HARMONICS    = 4,
  parameter int SINE_ENTRIES = 1024,
  parameter int PHASE_BITS   = 24,
  parameter int OUT_BITS     = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  pom_in_if.sink     in_i,
  pom_out_if.source  out_o,
  pom_cfg_if.sink    cfg_i
);
  localparam int NW   = (NOTES > 1) ? $clog2(NOTES) : 1;
  localparam int IW   = $clog2(SINE_ENTRIES);
  localparam int NLW  = pom_pkg::VOL_W + PHASE_BITS;
  localparam int MULW = pom_pkg::VOL_W + pom_pkg::WAVE_W + 1;
  localparam int ACCW = MULW + $clog2(NOTES) + 1;
  localparam int PRW  = ACCW + pom_pkg::GAIN_W + 1;

  localparam logic signed [PRW-1:0] LimPos = PRW'(64'd1 << 30);
  localparam logic signed [PRW-1:0] LimNeg = -LimPos;
  localparam logic signed [OUT_BITS-1:0] SmpMax = {1'b0, {(OUT_BITS-1){1'b1}}};
  localparam logic signed [OUT_BITS-1:0] SmpMin = {1'b1, {(OUT_BITS-1){1'b0}}};

  typedef enum logic [3:0] {
    ST_IDLE, ST_RD, ST_EVAL, ST_HRD, ST_HACC, ST_DIVS, ST_DIVW, ST_MAC, ST_ACC,
    ST_GAIN, ST_FIN
  } state_e;

  state_e state_q;

  // configuration
  logic [2:0]                      wave_q;
  logic [pom_pkg::PW_W-1:0]        pw_q;
  logic                            tri_st_q, saw_st_q;
  logic [pom_pkg::CFG_DATA_W-1:0]  wts_q;
  logic [pom_pkg::GAIN_W-1:0]      gain_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wave_q   <= '0;
      pw_q     <= pom_pkg::PULSE_WIDTH_RST;
      tri_st_q <= 1'b0;
      saw_st_q <= 1'b0;
      wts_q    <= pom_pkg::WEIGHTS_RST;
      gain_q   <= pom_pkg::GAIN_RST;
    end else if (cfg_i.valid) begin
      case (pom_pkg::cfg_reg_e'(cfg_i.index))
        pom_pkg::REG_WAVE_TYPE:   wave_q   <= cfg_i.data[2:0];
        pom_pkg::REG_PULSE_WIDTH: pw_q     <= cfg_i.data[pom_pkg::PW_W-1:0];
        pom_pkg::REG_TRI_STEPPED: tri_st_q <= cfg_i.data[0];
        pom_pkg::REG_SAW_STEPPED: saw_st_q <= cfg_i.data[0];
        pom_pkg::REG_HARM_WTS:    wts_q    <= cfg_i.data;
        pom_pkg::REG_MASTER_GAIN: gain_q   <= cfg_i.data[pom_pkg::GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // note memories
  logic [NW-1:0]          n_q;
  logic [NOTES-1:0]       note_vld_q, ph_vld_q;
  logic                   in_acc, set_we, ph_we;
  logic [NW-1:0]          set_addr;
  logic [NLW-1:0]         note_rd;
  logic [PHASE_BITS-1:0]  ph_rd, cur_ph, cur_inc, ph_next;
  logic [pom_pkg::VOL_W-1:0] cur_lvl;

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign set_addr   = NW'(in_i.note_index);
  assign set_we     = in_acc && in_i.mode && (32'(in_i.note_index) < NOTES);

  assign cur_lvl = note_vld_q[n_q] ? note_rd[NLW-1 -: pom_pkg::VOL_W] : '0;
  assign cur_inc = note_vld_q[n_q] ? note_rd[PHASE_BITS-1:0] : '0;
  assign cur_ph  = ph_vld_q[n_q] ? ph_rd : '0;
  assign ph_next = cur_ph + cur_inc;
  assign ph_we   = (state_q == ST_EVAL) && (cur_lvl != '0);

  pom_ram #(.Width(NLW), .Depth(NOTES)) u_note_ram (
    .clk_i   (clk_i),
    .we_i    (set_we),
    .waddr_i (set_addr),
    .wdata_i ({in_i.note_volume, PHASE_BITS'(in_i.phase_step)}),
    .raddr_i (n_q),
    .rdata_o (note_rd)
  );

  pom_ram #(.Width(PHASE_BITS), .Depth(NOTES)) u_phase_ram (
    .clk_i   (clk_i),
    .we_i    (ph_we),
    .waddr_i (n_q),
    .wdata_i (ph_next),
    .raddr_i (n_q),
    .rdata_o (ph_rd)
  );

  // simple waves
  logic [15:0]         p;
  logic signed [17:0]  d, ad, tri_y, saw_y;
  pom_pkg::wave_t      simple_wave;

  assign p     = cur_ph[PHASE_BITS-1 -: 16];
  assign d     = signed'({2'b00, p}) - 18'sd32768;
  assign ad    = d[17] ? -d : d;
  assign tri_y = (ad <<< 1) - 18'sd32768;
  assign saw_y = d;

  always_comb begin
    case (wave_q)
      pom_pkg::WAVE_PULSE: simple_wave = (p >= pw_q) ? -17'sd32768 : 17'sd32768;
      pom_pkg::WAVE_TRI:   simple_wave = tri_st_q ? 17'({tri_y[17:12], 12'd0})
                                                  : 17'(tri_y);
      pom_pkg::WAVE_SAW:   simple_wave = saw_st_q ? 17'({saw_y[17:12], 12'd0})
                                                  : 17'(saw_y);
      default:             simple_wave = '0;
    endcase
  end

  // harmonic sum
  logic [pom_pkg::NUM_WTS-1:0][pom_pkg::WT_W-1:0] wts;
  logic [pom_pkg::HCNT_W-1:0]   h_q;
  logic [PHASE_BITS-1:0]        ph_q, hp_q;
  logic [pom_pkg::WT_W-1:0]     hw;
  logic [pom_pkg::DEN_W-1:0]    wsum;
  logic signed [pom_pkg::SUM_W-1:0] sum_q, sum_mag;
  pom_pkg::wave_t               rom_rd;
  logic                         div_done;
  logic [pom_pkg::DIV_W-1:0]    quo;

  assign wts     = wts_q;
  assign hw      = (h_q < 3'd4) ? wts[h_q[1:0]] : '0;
  assign sum_mag = sum_q[pom_pkg::SUM_W-1] ? -sum_q : sum_q;

  always_comb begin
    wsum = '0;
    for (int i = 0; i < HARMONICS && i < pom_pkg::NUM_WTS; i++) begin
      wsum = wsum + pom_pkg::DEN_W'(wts[i]);
    end
  end

  pom_sine_rom #(.Entries(SINE_ENTRIES)) u_rom (
    .clk_i  (clk_i),
    .addr_i (hp_q[PHASE_BITS-1 -: IW]),
    .data_o (rom_rd)
  );

  pom_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (state_q == ST_DIVS),
    .dividend_i (sum_mag[pom_pkg::DIV_W-1:0]),
    .divisor_i  (wsum),
    .done_o     (div_done),
    .quotient_o (quo)
  );

  // mixer
  logic [pom_pkg::VOL_W-1:0]   lvl_q;
  pom_pkg::wave_t              wave_r_q;
  logic signed [MULW-1:0]      mul_q;
  logic signed [ACCW-1:0]      acc_q;
  logic signed [PRW-1:0]       prod_q, mag;
  logic [PRW-1:0]              shv;
  logic signed [OUT_BITS-1:0]  smp, smp_fin;
  logic                        clip_fin, out_free;

  assign mag = prod_q[PRW-1] ? -prod_q : prod_q;
  assign shv = PRW'(mag) >> (31 - OUT_BITS);
  assign smp = OUT_BITS'(shv);

  always_comb begin
    clip_fin = 1'b1;
    if (prod_q >= LimPos) begin
      smp_fin = SmpMax;
    end else if (prod_q <= LimNeg) begin
      smp_fin = SmpMin;
    end else begin
      clip_fin = 1'b0;
      smp_fin  = prod_q[PRW-1] ? -smp : smp;
    end
  end

  assign out_free = !out_o.valid || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q          <= ST_IDLE;
      n_q              <= '0;
      note_vld_q       <= '0;
      ph_vld_q         <= '0;
      h_q              <= '0;
      ph_q             <= '0;
      hp_q             <= '0;
      sum_q            <= '0;
      lvl_q            <= '0;
      wave_r_q         <= '0;
      mul_q            <= '0;
      acc_q            <= '0;
      prod_q           <= '0;
      out_o.valid      <= 1'b0;
      out_o.sample_out <= '0;
      out_o.clipped    <= 1'b0;
    end else begin
      if (out_o.valid && out_o.ready && state_q != ST_FIN) out_o.valid <= 1'b0;
      if (set_we) note_vld_q[set_addr] <= 1'b1;
      if (ph_we) ph_vld_q[n_q] <= 1'b1;
      case (state_q)
        ST_IDLE: begin
          if (in_acc && !in_i.mode) begin
            n_q     <= '0;
            acc_q   <= '0;
            state_q <= ST_RD;
          end
        end
        ST_RD: state_q <= ST_EVAL;
        ST_EVAL: begin
          lvl_q    <= cur_lvl;
          ph_q     <= cur_ph;
          hp_q     <= cur_ph;
          h_q      <= '0;
          sum_q    <= '0;
          wave_r_q <= simple_wave;
          state_q  <= (wave_q == pom_pkg::WAVE_HARM) ? ST_HRD : ST_MAC;
        end
        ST_HRD: state_q <= ST_HACC;
        ST_HACC: begin
          sum_q <= sum_q + pom_pkg::SUM_W'(signed'({1'b0, hw}) * rom_rd);
          hp_q  <= hp_q + ph_q;
          h_q   <= h_q + 1'b1;
          if (h_q == pom_pkg::HCNT_W'(HARMONICS - 1)) begin
            if (wsum == '0) begin
              wave_r_q <= '0;
              state_q  <= ST_MAC;
            end else begin
              state_q <= ST_DIVS;
            end
          end else begin
            state_q <= ST_HRD;
          end
        end
        ST_DIVS: state_q <= ST_DIVW;
        ST_DIVW: begin
          if (div_done) begin
            wave_r_q <= sum_q[pom_pkg::SUM_W-1] ? -pom_pkg::WAVE_W'(quo)
                                               : pom_pkg::WAVE_W'(quo);
            state_q  <= ST_MAC;
          end
        end
        ST_MAC: begin
          mul_q   <= signed'({1'b0, lvl_q}) * wave_r_q;
          state_q <= ST_ACC;
        end
        ST_ACC: begin
          acc_q <= acc_q + ACCW'(mul_q);
          if (n_q == NW'(NOTES - 1)) begin
            state_q <= ST_GAIN;
          end else begin
            n_q     <= n_q + 1'b1;
            state_q <= ST_RD;
          end
        end
        ST_GAIN: begin
          prod_q  <= PRW'(acc_q * signed'({1'b0, gain_q}));
          state_q <= ST_FIN;
        end
        ST_FIN: begin
          if (out_free) begin
            out_o.valid      <= 1'b1;
            out_o.sample_out <= smp_fin;
            out_o.clipped    <= clip_fin;
            state_q          <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  a_tick_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !in_i.mode) |=> (state_q == ST_RD && n_q == '0 && acc_q == '0))
    else $error("tick did not start from the first note");

  a_phase_wr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ph_we |-> (state_q == ST_EVAL && !set_we))
    else $error("phase write outside note evaluation");

  a_div_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIVW && div_done) |=> state_q == ST_MAC)
    else $error("divider result not taken");

  a_clip_val: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.clipped) |->
      (out_o.sample_out == SmpMax || out_o.sample_out == SmpMin))
    else $error("clipped sample not at a limit");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIN && !out_free) |=> state_q == ST_FIN)
    else $error("result lost while output slot full");
endmodule

[hdl/pom_ram.sv]
// generic single-port-write ram with registered read
`timescale 1ns / 1ps
module pom_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                                clk_i,
  input  logic                                we_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                    wdata_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                    rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

[hdl/pom_sine_rom.sv]
// sine table rom with registered read
`timescale 1ns / 1ps
module pom_sine_rom #(
  parameter int Entries = 1024
) (
  input  logic                       clk_i,
  input  logic [$clog2(Entries)-1:0] addr_i,
  output pom_pkg::wave_t             data_o
);
  typedef pom_pkg::wave_t tab_t [Entries];

  localparam logic [63:0] One   = 64'd1073741824;
  localparam logic [63:0] HalfPi = 64'd1686629713;

  function automatic pom_pkg::wave_t entry(input int unsigned k);
    logic [63:0] t, r, x, x2, a, s, v;
    logic [1:0]  q;
    t  = (64'(k) << 32) / Entries;
    q  = t[31:30];
    r  = t & (One - 64'd1);
    if (q[0]) r = One - r;
    x  = (r * HalfPi) >> 30;
    x2 = (x * x) >> 30;
    a  = One;
    a  = One - (((x2 * a) >> 30) / 110);
    a  = One - (((x2 * a) >> 30) / 72);
    a  = One - (((x2 * a) >> 30) / 42);
    a  = One - (((x2 * a) >> 30) / 20);
    a  = One - (((x2 * a) >> 30) / 6);
    s  = (x * a) >> 30;
    v  = (s + 64'd16384) >> 15;
    if (v > 64'd32768) v = 64'd32768;
    return q[1] ? -pom_pkg::WAVE_W'(v) : pom_pkg::WAVE_W'(v);
  endfunction

  function automatic tab_t build();
    tab_t tb;
    for (int k = 0; k < Entries; k++) begin
      tb[k] = entry(k);
    end
    return tb;
  endfunction

  localparam tab_t Tab = build();

  pom_pkg::wave_t data_q;

  always_ff @(posedge clk_i) begin
    data_q <= Tab[addr_i];
  end

  assign data_o = data_q;
endmodule

[hdl/pom_div.sv]
// restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module pom_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [pom_pkg::DIV_W-1:0]   dividend_i,
  input  logic [pom_pkg::DEN_W-1:0]   divisor_i,
  output logic                        done_o,
  output logic [pom_pkg::DIV_W-1:0]   quotient_o
);
  localparam int CntW = $clog2(pom_pkg::DIV_W);

  logic                        busy_q, done_q;
  logic [CntW-1:0]             cnt_q;
  logic [pom_pkg::DIV_W-1:0]   quo_q;
  logic [pom_pkg::DEN_W:0]     rem_q, rem_sh, rem_sub;
  logic [pom_pkg::DEN_W-1:0]   den_q;
  logic                        bit_ok;

  assign rem_sh  = {rem_q[pom_pkg::DEN_W-1:0], quo_q[pom_pkg::DIV_W-1]};
  assign bit_ok  = rem_sh >= {1'b0, den_q};
  assign rem_sub = rem_sh - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      quo_q  <= '0;
      rem_q  <= '0;
      den_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
        quo_q  <= dividend_i;
        rem_q  <= '0;
        den_q  <= divisor_i;
      end else if (busy_q) begin
        rem_q <= bit_ok ? rem_sub : rem_sh;
        quo_q <= {quo_q[pom_pkg::DIV_W-2:0], bit_ok};
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntW'(pom_pkg::DIV_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;
endmodule

[tb/tb_pom_pkg.sv]
// testbench constants for the polyphonic oscillator mixer
`timescale 1ns / 1ps
package tb_pom_pkg;

  localparam logic MODE_TICK     = 1'b0;
  localparam logic MODE_SET_NOTE = 1'b1;

  localparam logic [2:0] WAVE_SILENT     = 3'd4;
  localparam logic [2:0] WAVE_SILENT_TOP = 3'd7;

endpackage

[tb/testbench.sv]
// testbench for polyphonic_oscillator_mixer: bit-accurate mixer prediction checked per sample
`timescale 1ns / 1ps
module testbench;

  localparam int NOTE_CNT   = 16;
  localparam int SINE_N     = 1024;
  localparam int SETTLE     = 20;
  localparam longint LIMIT  = 6000000;
  localparam longint Q30    = 64'd1073741824;
  localparam longint HALFPI = 64'd1686629713;

  typedef struct packed {
    logic signed [15:0] sample;
    logic               clip;
  } sample_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  pom_in_if  in_if();
  pom_out_if out_if();
  pom_cfg_if cfg_if();

  polyphonic_oscillator_mixer DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  always #1 clk_i = ~clk_i;

  // mixer model state
  int             sine_rom [SINE_N];
  logic [23:0]    phase_acc [NOTE_CNT];
  logic [8:0]     level_mem [NOTE_CNT];
  logic [23:0]    step_mem [NOTE_CNT];
  logic [2:0]     wave_sel;
  logic [15:0]    duty;
  logic           tri_quant;
  logic           saw_quant;
  logic [31:0]    harm_wts;
  logic [8:0]     gain;

  sample_t expected_samples[$];
  int      errors;
  int      send_idle_pct;
  int      recv_stall_pct;
  int      hold_off;
  longint  cycles;

  function automatic int sine_value(int k);
    logic [63:0] t, r, x, x2, a, s, v;
    logic [1:0] q;
    logic [63:0] den [5];
    den = '{64'd110, 64'd72, 64'd42, 64'd20, 64'd6};
    t = (64'(k) << 32) / SINE_N;
    q = t[31:30];
    r = t & (Q30 - 1);
    if (q[0]) r = Q30 - r;
    x = (r * HALFPI) >> 30;
    x2 = (x * x) >> 30;
    a = Q30;
    for (int i = 0; i < 5; i++) a = Q30 - (((x2 * a) >> 30) / den[i]);
    s = (x * a) >> 30;
    v = (s + 64'd16384) >> 15;
    if (v > 64'd32768) v = 64'd32768;
    return q[1] ? -int'(v) : int'(v);
  endfunction

  function automatic int floor_step(int y);
    return y - (y & 4095);
  endfunction

  function automatic longint wave_value(logic [23:0] ph);
    int p, y;
    longint acc, wsum, w;
    logic [63:0] hp;
    p = int'(ph[23:8]);
    case (wave_sel)
      pom_pkg::WAVE_PULSE: return (p >= int'(duty)) ? -32768 : 32768;
      pom_pkg::WAVE_TRI: begin
        y = p - 32768;
        if (y < 0) y = -y;
        y = 2 * y - 32768;
        return tri_quant ? floor_step(y) : y;
      end
      pom_pkg::WAVE_SAW: begin
        y = p - 32768;
        return saw_quant ? floor_step(y) : y;
      end
      pom_pkg::WAVE_HARM: begin
        acc = 0;
        wsum = 0;
        for (int h = 0; h < pom_pkg::NUM_WTS; h++) begin
          w = longint'(harm_wts[8*h +: 8]);
          hp = (64'(ph) * (h + 1)) & 64'hFFFFFF;
          wsum += w;
          acc += w * sine_rom[hp[23:14]];
        end
        return (wsum == 0) ? 0 : acc / wsum;
      end
      default: return 0;
    endcase
  endfunction

  function automatic sample_t mix_tick();
    sample_t r;
    longint acc, prod;
    acc = 0;
    for (int n = 0; n < NOTE_CNT; n++) acc += longint'(level_mem[n]) * wave_value(phase_acc[n]);
    prod = acc * longint'(gain);
    r.clip = 1'b0;
    if (prod >= Q30) begin
      r.sample = 16'sd32767;
      r.clip = 1'b1;
    end else if (prod <= -Q30) begin
      r.sample = -16'sd32768;
      r.clip = 1'b1;
    end else if (prod >= 0) begin
      r.sample = 16'(prod >> 15);
    end else begin
      r.sample = 16'(-((-prod) >> 15));
    end
    for (int n = 0; n < NOTE_CNT; n++)
      if (level_mem[n] != 0) phase_acc[n] = phase_acc[n] + step_mem[n];
    return r;
  endfunction

  task automatic send_item(logic mode, logic [3:0] idx, logic [8:0] vol, logic [23:0] step);
    int gap;
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      gap = $urandom_range(6, 1);
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid       <= 1'b1;
    in_if.mode        <= mode;
    in_if.note_index  <= idx;
    in_if.note_volume <= vol;
    in_if.phase_step  <= step;
    do @(posedge clk_i); while (!in_if.ready);
    if (mode == tb_pom_pkg::MODE_SET_NOTE) begin
      level_mem[idx] = vol;
      step_mem[idx]  = step;
    end else begin
      expected_samples.push_back(mix_tick());
    end
  endtask

  task automatic release_input();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic wait_idle();
    wait (expected_samples.size() == 0);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(pom_pkg::cfg_reg_e idx, logic [31:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    do @(posedge clk_i); while (!cfg_if.ready);
    case (idx)
      pom_pkg::REG_WAVE_TYPE:   wave_sel  = data[2:0];
      pom_pkg::REG_PULSE_WIDTH: duty      = data[15:0];
      pom_pkg::REG_TRI_STEPPED: tri_quant = data[0];
      pom_pkg::REG_SAW_STEPPED: saw_quant = data[0];
      pom_pkg::REG_HARM_WTS:    harm_wts  = data;
      pom_pkg::REG_MASTER_GAIN: gain      = data[8:0];
      default: ;
    endcase
  endtask

  task automatic load_config(logic [2:0] wt, logic [15:0] pw, logic ts, logic ss,
                             logic [31:0] wts, logic [8:0] g);
    wait_idle();
    write_reg(pom_pkg::REG_WAVE_TYPE, 32'(wt));
    write_reg(pom_pkg::REG_PULSE_WIDTH, 32'(pw));
    write_reg(pom_pkg::REG_TRI_STEPPED, 32'(ts));
    write_reg(pom_pkg::REG_SAW_STEPPED, 32'(ss));
    write_reg(pom_pkg::REG_HARM_WTS, wts);
    write_reg(pom_pkg::REG_MASTER_GAIN, 32'(g));
    cfg_if.valid <= 1'b0;
  endtask

  function automatic logic [8:0] rand_volume();
    case ($urandom_range(9))
      0, 1:    return 9'd0;
      2:       return 9'($urandom_range(511, 256));
      3:       return 9'($urandom_range(256));
      default: return 9'($urandom_range(24));
    endcase
  endfunction

  function automatic logic [23:0] rand_step();
    case ($urandom_range(3))
      0:       return 24'($urandom_range(16777215));
      1:       return 24'($urandom_range(4095));
      default: return 24'($urandom_range(1 << 20));
    endcase
  endfunction

  task automatic send_random(int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(9) < 4) send_item(tb_pom_pkg::MODE_SET_NOTE, 4'($urandom_range(15)),
                                           rand_volume(), rand_step());
      else send_item(tb_pom_pkg::MODE_TICK, 4'($urandom), 9'($urandom), 24'($urandom));
    end
    release_input();
  endtask

  task automatic random_config();
    logic [8:0] g;
    case ($urandom_range(3))
      0:       g = 9'($urandom_range(511));
      1:       g = 9'd256;
      default: g = 9'($urandom_range(64));
    endcase
    load_config(3'($urandom_range(7)), 16'($urandom), 1'($urandom), 1'($urandom),
                ($urandom_range(4) == 0) ? 32'd0 : $urandom, g);
  endtask

  task automatic test_directed();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    send_item(tb_pom_pkg::MODE_TICK, 4'd0, 9'd0, 24'd0);
    send_item(tb_pom_pkg::MODE_SET_NOTE, 4'd0, 9'd256, 24'hFFFFFF);
    send_item(tb_pom_pkg::MODE_SET_NOTE, 4'd15, 9'd511, 24'h000001);
    send_item(tb_pom_pkg::MODE_SET_NOTE, 4'd7, 9'd0, 24'h800000);
    send_item(tb_pom_pkg::MODE_TICK, 4'hF, 9'h1FF, 24'hFFFFFF);
    send_item(tb_pom_pkg::MODE_TICK, 4'd0, 9'd0, 24'd0);
    release_input();
    load_config(pom_pkg::WAVE_PULSE, 16'd0, 1'b0, 1'b0, 32'd0, 9'd511);
    send_item(tb_pom_pkg::MODE_TICK, 4'd0, 9'd0, 24'd0);
    send_item(tb_pom_pkg::MODE_SET_NOTE, 4'd15, 9'd3, 24'h400000);
    send_item(tb_pom_pkg::MODE_TICK, 4'd0, 9'd0, 24'd0);
    release_input();
    load_config(pom_pkg::WAVE_PULSE, 16'hFFFF, 1'b1, 1'b1, 32'hFFFFFFFF, 9'd0);
    send_item(tb_pom_pkg::MODE_TICK, 4'd0, 9'd0, 24'd0);
    release_input();
    load_config(pom_pkg::WAVE_TRI, 16'h8000, 1'b1, 1'b0, 32'h0, 9'd1);
    send_item(tb_pom_pkg::MODE_SET_NOTE, 4'd0, 9'd1, 24'h123456);
    send_item(tb_pom_pkg::MODE_TICK, 4'd0, 9'd0, 24'd0);
    send_item(tb_pom_pkg::MODE_TICK, 4'd0, 9'd0, 24'd0);
    release_input();
    load_config(pom_pkg::WAVE_SAW, 16'h8000, 1'b0, 1'b1, 32'h0, 9'd2);
    send_item(tb_pom_pkg::MODE_TICK, 4'd0, 9'd0, 24'd0);
    release_input();
    load_config(pom_pkg::WAVE_HARM, 16'h8000, 1'b0, 1'b0, 32'h0, 9'd256);
    send_item(tb_pom_pkg::MODE_TICK, 4'd0, 9'd0, 24'd0);
    release_input();
    load_config(pom_pkg::WAVE_HARM, 16'h8000, 1'b0, 1'b0, 32'h40FF01FF, 9'd3);
    send_item(tb_pom_pkg::MODE_TICK, 4'd0, 9'd0, 24'd0);
    release_input();
    load_config(tb_pom_pkg::WAVE_SILENT, 16'h8000, 1'b0, 1'b0, 32'hFF, 9'd511);
    send_item(tb_pom_pkg::MODE_TICK, 4'd0, 9'd0, 24'd0);
    release_input();
    load_config(tb_pom_pkg::WAVE_SILENT_TOP, 16'h8000, 1'b0, 1'b0, 32'hFF, 9'd511);
    send_item(tb_pom_pkg::MODE_TICK, 4'd0, 9'd0, 24'd0);
    release_input();
    for (int n = 0; n < NOTE_CNT; n++)
      send_item(tb_pom_pkg::MODE_SET_NOTE, 4'(n), 9'd0, 24'd0);
    release_input();
  endtask

  task automatic test_random_traffic();
    for (int ph = 0; ph < 8; ph++) begin
      random_config();
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 65; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 65; end
        default: begin send_idle_pct = 6; recv_stall_pct = 6; end
      endcase
      send_random(135);
    end
  endtask

  task automatic test_backpressure();
    random_config();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_off = 800;
    send_random(20);
  endtask

  task automatic test_drain_pause();
    send_idle_pct = 6;
    recv_stall_pct = 6;
    send_random(20);
    wait (expected_samples.size() == 0);
    send_random(20);
  endtask

  // sample checking and receiver stalls
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (expected_samples.size() == 0) begin
        $display("%0t: unexpected sample %0d clipped %0b", $time, out_if.sample_out,
                 out_if.clipped);
        errors++;
      end else begin
        sample_t e;
        e = expected_samples.pop_front();
        if (out_if.sample_out !== e.sample) begin
          $display("%0t: sample_out expected %0d actual %0d", $time, e.sample,
                   out_if.sample_out);
          errors++;
        end
        if (out_if.clipped !== e.clip) begin
          $display("%0t: clipped expected %0b actual %0b", $time, e.clip, out_if.clipped);
          errors++;
        end
      end
    end
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    errors = 0;
    cycles = 0;
    hold_off = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    for (int k = 0; k < SINE_N; k++) sine_rom[k] = sine_value(k);
    for (int n = 0; n < NOTE_CNT; n++) begin
      phase_acc[n] = '0;
      level_mem[n] = '0;
      step_mem[n]  = '0;
    end
    wave_sel  = pom_pkg::WAVE_PULSE;
    duty      = pom_pkg::PULSE_WIDTH_RST;
    tri_quant = 1'b0;
    saw_quant = 1'b0;
    harm_wts  = pom_pkg::WEIGHTS_RST;
    gain      = pom_pkg::GAIN_RST;
    rst_ni            <= 1'b0;
    in_if.valid       <= 1'b0;
    in_if.mode        <= tb_pom_pkg::MODE_TICK;
    in_if.note_index  <= '0;
    in_if.note_volume <= '0;
    in_if.phase_step  <= '0;
    cfg_if.valid      <= 1'b0;
    cfg_if.index      <= pom_pkg::REG_WAVE_TYPE;
    cfg_if.data       <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random_traffic();
    test_backpressure();
    test_drain_pause();
    wait (expected_samples.size() == 0);
    repeat (SETTLE) @(posedge clk_i);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

[filelist.f]
hdl/pom_pkg.sv
hdl/pom_in_if.sv
hdl/pom_out_if.sv
hdl/pom_cfg_if.sv
hdl/pom_ram.sv
hdl/pom_sine_rom.sv
hdl/pom_div.sv
hdl/polyphonic_oscillator_mixer.sv
tb/tb_pom_pkg.sv
tb/testbench.sv
